// ===== rtl/ttfc_pkg.sv =====
// Package for the transit-time flow calculation unit.
// Holds payload and control types, status and register codes, and fixed constants.
// No dependencies.
package ttfc_pkg;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_INVALID_TOF  = 3'd1,
		ST_NUMERIC      = 3'd2,
		ST_TEMP_MISSING = 3'd3,
		ST_TEMP_STALE   = 3'd4,
		ST_PROFILE      = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_FWD  = 2'd1,
		DIR_REV  = 2'd2
	} dir_t;

	typedef enum logic [2:0] {
		REG_PROFILE = 3'd0,
		REG_SPEED   = 3'd1,
		REG_PATH    = 3'd2,
		REG_AREA    = 3'd3,
		REG_GAIN    = 3'd4,
		REG_OFFSET  = 3'd5,
		REG_SHIFT   = 3'd6
	} reg_idx_t;

	localparam logic signed [63:0] TOF_MIN  = 64'sd8000000;
	localparam logic signed [63:0] TOF_MAX  = 64'sd8000000000;
	localparam logic signed [31:0] TEMP_MIN = -32'sd50000;
	localparam logic signed [31:0] TEMP_MAX = 32'sd150000;
	localparam logic [63:0] AGE_MAX   = 64'd5000000;
	localparam logic [63:0] DEN_SCALE = 64'd2000000000000;
	localparam logic signed [31:0] PATH_MAX = 32'sd4611686;
	localparam logic [94:0] NUM_P_MAX = 95'd9223372036854775;
	localparam logic [63:0] MILLI     = 64'd1000;

	localparam int VQ_W  = 23;
	localparam int X_W   = 54;
	localparam int RAW_W = 44;
	localparam logic [44:0] RECIP = 45'd18014398509481;

	typedef struct packed {
		logic signed [63:0] tof_upstream;
		logic signed [63:0] tof_downstream;
		logic signed [31:0] temp_mdeg;
		logic               temp_ok;
		logic [63:0]        flow_time_us;
		logic [63:0]        temp_time_us;
	} in_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [63:0] flow_rate;
		logic [1:0]         direction;
		logic [31:0]        accepted_total;
		logic [31:0]        rejected_total;
	} out_t;

	typedef struct packed {
		logic               profile_loaded;
		logic signed [31:0] sound_speed;
		logic signed [31:0] path_len;
		logic signed [31:0] pipe_cross_area;
		logic signed [31:0] cal_gain;
		logic signed [63:0] cal_offset;
		logic [5:0]         cal_shift;
	} cfg_t;

	typedef struct packed {
		status_t status;
		logic    calc;
		logic    count;
	} ctl_t;

endpackage

// ===== rtl/ttfc_front.sv =====
// Front stages: sample checks, c squared, delta-t product, numerator and denominator.
// Depends on ttfc_pkg.
module ttfc_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_in,
	input  ttfc_pkg::in_t  smp,
	input  ttfc_pkg::cfg_t cfg,
	output logic          v_out,
	output ttfc_pkg::ctl_t ctl_out,
	output logic          neg_out,
	output logic [63:0]   num,
	output logic [63:0]   den
);
	import ttfc_pkg::*;

	logic [63:0] age;
	logic        stale, range_bad, temp_bad;
	logic [33:0] d_pos, d_rev;
	ctl_t        ctl_d, ctl5_d;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic dneg_s1, dneg_s2, dneg_s3, dneg_s4, dneg_s5;
	logic [32:0] dmag_s1, dmag_s2;
	logic [61:0] c2_s2;
	logic [63:0] den_s2, den_s3, den_s4, den_s5;
	logic [47:0] hh_s3, lh_s3;
	logic [46:0] hl_s3, ll_s3;
	logic [94:0] p_s4;
	logic [63:0] num_s5;

	always_comb begin
		age = (smp.flow_time_us >= smp.temp_time_us) ? smp.flow_time_us - smp.temp_time_us
			: smp.temp_time_us - smp.flow_time_us;
		stale = age > AGE_MAX;
		range_bad = (smp.tof_upstream < TOF_MIN) || (smp.tof_downstream < TOF_MIN) ||
			(smp.tof_upstream > TOF_MAX) || (smp.tof_downstream > TOF_MAX) ||
			(cfg.path_len <= 32'sd0) || (cfg.pipe_cross_area <= 32'sd0) ||
			(cfg.sound_speed <= 32'sd0);
		temp_bad = (smp.temp_mdeg < TEMP_MIN) || (smp.temp_mdeg > TEMP_MAX);
		d_pos = smp.tof_downstream[33:0] - smp.tof_upstream[33:0];
		d_rev = smp.tof_upstream[33:0] - smp.tof_downstream[33:0];
		ctl_d = '{status: ST_OK, calc: 1'b1, count: 1'b1};
		if (!cfg.profile_loaded) begin
			ctl_d = '{status: ST_PROFILE, calc: 1'b0, count: 1'b0};
		end else if (!smp.temp_ok) begin
			ctl_d = '{status: ST_TEMP_MISSING, calc: 1'b0, count: 1'b0};
		end else if (stale) begin
			ctl_d = '{status: ST_TEMP_STALE, calc: 1'b0, count: 1'b0};
		end else if (range_bad) begin
			ctl_d = '{status: ST_INVALID_TOF, calc: 1'b0, count: 1'b1};
		end else if (temp_bad) begin
			ctl_d = '{status: ST_TEMP_MISSING, calc: 1'b0, count: 1'b1};
		end else if (cfg.path_len > PATH_MAX) begin
			ctl_d = '{status: ST_NUMERIC, calc: 1'b0, count: 1'b1};
		end
	end

	always_comb begin
		ctl5_d = ctl_s4;
		if (ctl_s4.calc && (p_s4 > NUM_P_MAX)) begin
			ctl5_d = '{status: ST_NUMERIC, calc: 1'b0, count: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1  <= ctl_d;
			dneg_s1 <= d_pos[33];
			dmag_s1 <= d_pos[33] ? d_rev[32:0] : d_pos[32:0];

			ctl_s2  <= ctl_s1;
			dneg_s2 <= dneg_s1;
			dmag_s2 <= dmag_s1;
			c2_s2   <= 62'(cfg.sound_speed[30:0]) * 62'(cfg.sound_speed[30:0]);
			den_s2  <= 64'(cfg.path_len[22:0]) * DEN_SCALE;

			ctl_s3  <= ctl_s2;
			dneg_s3 <= dneg_s2;
			den_s3  <= den_s2;
			hh_s3   <= 48'(c2_s2[61:31]) * 48'(dmag_s2[32:16]);
			hl_s3   <= 47'(c2_s2[61:31]) * 47'(dmag_s2[15:0]);
			lh_s3   <= 48'(c2_s2[30:0]) * 48'(dmag_s2[32:16]);
			ll_s3   <= 47'(c2_s2[30:0]) * 47'(dmag_s2[15:0]);

			ctl_s4  <= ctl_s3;
			dneg_s4 <= dneg_s3;
			den_s4  <= den_s3;
			p_s4    <= (95'(hh_s3) << 47) + (95'(hl_s3) << 31) + (95'(lh_s3) << 16)
				+ 95'(ll_s3);

			ctl_s5  <= ctl5_d;
			dneg_s5 <= dneg_s4;
			den_s5  <= den_s4;
			num_s5  <= 64'(p_s4[53:0]) * MILLI;
		end
	end

	assign v_out   = v_s5;
	assign ctl_out = ctl_s5;
	assign neg_out = dneg_s5;
	assign num     = num_s5;
	assign den     = den_s5;

endmodule

// ===== rtl/ttfc_div.sv =====
// Velocity divider: one restoring quotient bit per pipeline stage.
// Depends on ttfc_pkg.
module ttfc_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  v_in,
	input  ttfc_pkg::ctl_t         ctl_in,
	input  logic                  neg_in,
	input  logic [63:0]           num,
	input  logic [63:0]           den,
	output logic                  v_out,
	output ttfc_pkg::ctl_t         ctl_out,
	output logic                  neg_out,
	output logic [ttfc_pkg::VQ_W-1:0] quo
);
	import ttfc_pkg::*;

	logic            v_sd   [VQ_W];
	ctl_t            ctl_sd [VQ_W];
	logic            neg_sd [VQ_W];
	logic [63:0]     rem_sd [VQ_W];
	logic [63:0]     den_sd [VQ_W];
	logic [VQ_W-1:0] quo_sd [VQ_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < VQ_W; j++) begin
				v_sd[j] <= 1'b0;
			end
		end else if (en) begin
			v_sd[0] <= v_in;
			for (int j = 1; j < VQ_W; j++) begin
				v_sd[j] <= v_sd[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_sd[0] <= ctl_in;
			neg_sd[0] <= neg_in;
			den_sd[0] <= den;
			if ((num >> (VQ_W - 1)) >= den) begin
				rem_sd[0] <= num - (den << (VQ_W - 1));
				quo_sd[0] <= VQ_W'(1);
			end else begin
				rem_sd[0] <= num;
				quo_sd[0] <= '0;
			end
			for (int j = 1; j < VQ_W; j++) begin
				ctl_sd[j] <= ctl_sd[j-1];
				neg_sd[j] <= neg_sd[j-1];
				den_sd[j] <= den_sd[j-1];
				if ((rem_sd[j-1] >> (VQ_W - 1 - j)) >= den_sd[j-1]) begin
					rem_sd[j] <= rem_sd[j-1] - (den_sd[j-1] << (VQ_W - 1 - j));
					quo_sd[j] <= {quo_sd[j-1][VQ_W-2:0], 1'b1};
				end else begin
					rem_sd[j] <= rem_sd[j-1];
					quo_sd[j] <= {quo_sd[j-1][VQ_W-2:0], 1'b0};
				end
			end
		end
	end

	assign v_out   = v_sd[VQ_W-1];
	assign ctl_out = ctl_sd[VQ_W-1];
	assign neg_out = neg_sd[VQ_W-1];
	assign quo     = quo_sd[VQ_W-1];

endmodule

// ===== rtl/ttfc_back.sv =====
// Back stages: area product, divide by 1000, calibration gain, shift and offset.
// Depends on ttfc_pkg.
module ttfc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  v_in,
	input  ttfc_pkg::ctl_t         ctl_in,
	input  logic                  neg_in,
	input  logic [ttfc_pkg::VQ_W-1:0] vel,
	input  ttfc_pkg::cfg_t         cfg,
	output logic                  v_out,
	output ttfc_pkg::ctl_t         ctl_out,
	output logic signed [63:0]    flow
);
	import ttfc_pkg::*;

	logic [98:0]  prod;
	logic [53:0]  rem;
	logic [31:0]  gmag;
	logic [75:0]  smag;
	logic         s_ovf;
	logic [64:0]  sum;
	ctl_t         ctl6_d, ctl8_d;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7, ctl_s8;
	logic neg_s1, neg_s2, neg_s3, neg_s4, sneg_s5;
	logic [X_W-1:0] x_s1, x_s2, x_s3;
	logic [49:0] hh_s2, lh_s2;
	logic [48:0] hl_s2, ll_s2;
	logic [44:0] q0_s3;
	logic [RAW_W-1:0] raw_s4;
	logic [53:0] ph_s5, pl_s5;
	logic signed [63:0] scaled_s6, sh_s7, flow_s8;

	always_comb begin
		prod = (99'(hh_s2) << 49) + (99'(hl_s2) << 27) + (99'(lh_s2) << 22) + 99'(ll_s2);
		rem  = x_s3 - 54'(q0_s3) * 54'd1000;
		gmag = cfg.cal_gain[31] ? 32'd0 - cfg.cal_gain : cfg.cal_gain;
		smag = (76'(ph_s5) << 22) + 76'(pl_s5);
		s_ovf = sneg_s5 ? (smag > 76'h8000000000000000) : (smag > 76'h7FFFFFFFFFFFFFFF);
		sum  = {sh_s7[63], sh_s7} + {cfg.cal_offset[63], cfg.cal_offset};
		ctl6_d = ctl_s5;
		if (ctl_s5.calc && s_ovf) begin
			ctl6_d = '{status: ST_NUMERIC, calc: 1'b0, count: 1'b1};
		end
		ctl8_d = ctl_s7;
		if (ctl_s7.calc) begin
			ctl8_d.calc = 1'b0;
			ctl8_d.status = (sum[64] != sum[63]) ? ST_NUMERIC : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl_in;
			neg_s1 <= neg_in;
			x_s1   <= 54'(vel) * 54'(cfg.pipe_cross_area[30:0]);

			ctl_s2 <= ctl_s1;
			neg_s2 <= neg_s1;
			x_s2   <= x_s1;
			hh_s2  <= 50'(x_s1[53:27]) * 50'(RECIP[44:22]);
			hl_s2  <= 49'(x_s1[53:27]) * 49'(RECIP[21:0]);
			lh_s2  <= 50'(x_s1[26:0]) * 50'(RECIP[44:22]);
			ll_s2  <= 49'(x_s1[26:0]) * 49'(RECIP[21:0]);

			ctl_s3 <= ctl_s2;
			neg_s3 <= neg_s2;
			x_s3   <= x_s2;
			q0_s3  <= prod[98:54];

			ctl_s4 <= ctl_s3;
			neg_s4 <= neg_s3;
			raw_s4 <= (rem >= 54'd1000) ? RAW_W'(q0_s3 + 45'd1) : RAW_W'(q0_s3);

			ctl_s5  <= ctl_s4;
			sneg_s5 <= neg_s4 ^ cfg.cal_gain[31];
			ph_s5   <= 54'(raw_s4[43:22]) * 54'(gmag);
			pl_s5   <= 54'(raw_s4[21:0]) * 54'(gmag);

			ctl_s6    <= ctl6_d;
			scaled_s6 <= sneg_s5 ? 64'd0 - smag[63:0] : smag[63:0];

			ctl_s7 <= ctl_s6;
			sh_s7  <= scaled_s6 >>> cfg.cal_shift;

			ctl_s8  <= ctl8_d;
			flow_s8 <= sum[63:0];
		end
	end

	assign v_out   = v_s8;
	assign ctl_out = ctl_s8;
	assign flow    = flow_s8;

endmodule

// ===== rtl/transit_time_flow_calc_unit.sv =====
// Top level of the transit-time flow calculation unit.
// Depends on ttfc_pkg, ttfc_front, ttfc_div and ttfc_back.
//
// Usage:
//   sample channel (sample_valid/sample_ready/sample) takes one time-of-flight pair with
//   its temperature and timestamps per beat. result channel (result_valid/result_ready/
//   result) returns one beat per sample: status, calibrated flow, direction and the
//   accepted and rejected totals after that sample.
//   Configuration: write cfg_data into register cfg_addr while cfg_we is high; write
//   only while no sample is in flight.
// Pipeline:
//   A sample passes 5 front stages, 23 divider stages (one quotient bit each), 8 back
//   stages and the result register on its way from sample beat to result beat.
//   Throughput is one sample per cycle while the result channel does not stall.
// Reset:
//   arst_n clears all valid bits, both totals and every configuration register.
// Stall:
//   While result_valid is high and result_ready low, the whole pipeline holds and
//   sample_ready is low; nothing is dropped or repeated.
module transit_time_flow_calc_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           sample_valid,
	output logic           sample_ready,
	input  ttfc_pkg::in_t  sample,
	output logic           result_valid,
	input  logic           result_ready,
	output ttfc_pkg::out_t result,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_addr,
	input  logic [63:0]    cfg_data
);
	import ttfc_pkg::*;

	logic  en;
	cfg_t  cfg_q;
	logic [31:0] acc_q, rej_q, acc_d, rej_d;

	logic        f_v, d_v, b_v;
	ctl_t        f_ctl, d_ctl, b_ctl;
	logic        f_neg, d_neg;
	logic [63:0] f_num, f_den;
	logic [VQ_W-1:0] d_quo;
	logic signed [63:0] b_flow;

	logic res_v_q;
	out_t res_q, res_d;

	assign en = !res_v_q || result_ready;
	assign sample_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_PROFILE: cfg_q.profile_loaded  <= cfg_data[0];
				REG_SPEED:   cfg_q.sound_speed     <= cfg_data[31:0];
				REG_PATH:    cfg_q.path_len        <= cfg_data[31:0];
				REG_AREA:    cfg_q.pipe_cross_area <= cfg_data[31:0];
				REG_GAIN:    cfg_q.cal_gain        <= cfg_data[31:0];
				REG_OFFSET:  cfg_q.cal_offset      <= cfg_data;
				REG_SHIFT:   cfg_q.cal_shift       <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	ttfc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (sample_valid),
		.smp     (sample),
		.cfg     (cfg_q),
		.v_out   (f_v),
		.ctl_out (f_ctl),
		.neg_out (f_neg),
		.num     (f_num),
		.den     (f_den)
	);

	ttfc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (f_v),
		.ctl_in  (f_ctl),
		.neg_in  (f_neg),
		.num     (f_num),
		.den     (f_den),
		.v_out   (d_v),
		.ctl_out (d_ctl),
		.neg_out (d_neg),
		.quo     (d_quo)
	);

	ttfc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (d_v),
		.ctl_in  (d_ctl),
		.neg_in  (d_neg),
		.vel     (d_quo),
		.cfg     (cfg_q),
		.v_out   (b_v),
		.ctl_out (b_ctl),
		.flow    (b_flow)
	);

	always_comb begin
		acc_d = acc_q;
		rej_d = rej_q;
		if (b_v && b_ctl.count) begin
			if (b_ctl.status == ST_OK) begin
				acc_d = acc_q + 32'd1;
			end else begin
				rej_d = rej_q + 32'd1;
			end
		end
		res_d.status = b_ctl.status;
		res_d.flow_rate = (b_ctl.status == ST_OK) ? b_flow : 64'sd0;
		res_d.direction = DIR_NONE;
		if (b_ctl.status == ST_OK && b_flow > 64'sd0) begin
			res_d.direction = DIR_FWD;
		end else if (b_ctl.status == ST_OK && b_flow < 64'sd0) begin
			res_d.direction = DIR_REV;
		end
		res_d.accepted_total = acc_d;
		res_d.rejected_total = rej_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
			acc_q   <= '0;
			rej_q   <= '0;
		end else if (en) begin
			res_v_q <= b_v;
			acc_q   <= acc_d;
			rej_q   <= rej_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res_d;
		end
	end

	assign result_valid = res_v_q;
	assign result       = res_q;

`ifndef SYNTHESIS
	a_acc_moves_on_beat: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(acc_q) |-> $past(en && b_v))
		else $error("accepted total moved without a finished beat");

	a_one_counter: assert property (@(posedge clk) disable iff (!arst_n)
		!(!$stable(acc_q) && !$stable(rej_q)))
		else $error("both totals moved for one beat");

	a_zero_unless_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status != ST_OK) |->
		(result.flow_rate == 64'sd0) && (result.direction == DIR_NONE))
		else $error("flow or direction set on a failed beat");
`endif

endmodule
